@@ rtl/core/u8sd_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned USED_W   = 3;
    localparam int unsigned SEQ_W    = 3;
    localparam int unsigned TAKEN_W  = 2;
    localparam int unsigned RCNT_W   = 2;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 32;

    localparam logic [CP_W-1:0]   REPL_CP   = 21'h00FFFD;
    localparam logic [USED_W-1:0] USED_ONE  = 3'd1;
    localparam logic [SEQ_W-1:0]  SEQ_IDLE  = 3'd0;
    localparam logic [SEQ_W-1:0]  SEQ_TWO   = 3'd2;
    localparam logic [SEQ_W-1:0]  SEQ_THREE = 3'd3;
    localparam logic [SEQ_W-1:0]  SEQ_FOUR  = 3'd4;

    // Results caused by one input byte: replacements for a broken
    // sequence first, then at most one result of the byte itself.
    typedef struct packed {
        logic [RCNT_W-1:0] rep_cnt;
        logic              has_fresh;
        logic [CP_W-1:0]   fresh_cp;
        logic              fresh_rep;
        logic [USED_W-1:0] fresh_used;
    } group_t;

endpackage

@@ rtl/core/u8sd_step.sv @@
// Sequence state and per-byte decode logic of the UTF-8 stream decoder.
module u8sd_step (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         take,
    input  logic [u8sd_pkg::BYTE_W-1:0]  data_byte,
    output u8sd_pkg::group_t             grp
);
    import u8sd_pkg::*;

    logic [SEQ_W-1:0]   seq_reg,   seq_next;
    logic [TAKEN_W-1:0] taken_reg, taken_next;
    logic [CP_W-1:0]    acc_reg,   acc_next;

    logic [TAKEN_W-1:0] taken_inc;
    logic [TAKEN_W-1:0] taken_sat;
    logic [RCNT_W-1:0]  flush_cnt;
    logic [CP_W-1:0]    acc_shift;
    logic               seq_done;
    logic               is_cont;

    assign is_cont   = (data_byte[7:6] == 2'b10);
    assign taken_inc = taken_reg + 2'd1;
    assign taken_sat = (taken_reg == 2'd3) ? 2'd2 : taken_reg;
    assign flush_cnt = taken_sat + 2'd1;
    assign acc_shift = {acc_reg[CP_W-7:0], data_byte[5:0]};
    assign seq_done  = ({1'b0, taken_inc} + 3'd1) >= seq_reg;

    always_comb begin
        seq_next   = seq_reg;
        taken_next = taken_reg;
        acc_next   = acc_reg;
        grp        = '0;
        if (data_byte == '0) begin
            if (seq_reg != SEQ_IDLE) begin
                grp.rep_cnt = flush_cnt;
            end
            seq_next   = SEQ_IDLE;
            taken_next = '0;
            acc_next   = '0;
        end else if (seq_reg != SEQ_IDLE && is_cont) begin
            acc_next   = acc_shift;
            taken_next = taken_inc;
            if (seq_done) begin
                grp.has_fresh  = 1'b1;
                grp.fresh_cp   = acc_shift;
                grp.fresh_rep  = 1'b0;
                grp.fresh_used = seq_reg;
                seq_next       = SEQ_IDLE;
                taken_next     = '0;
                acc_next       = '0;
            end
        end else begin
            // A broken sequence is flushed, then the byte starts afresh.
            if (seq_reg != SEQ_IDLE) begin
                grp.rep_cnt = flush_cnt;
            end
            seq_next   = SEQ_IDLE;
            taken_next = '0;
            acc_next   = '0;
            if (!data_byte[7]) begin
                grp.has_fresh  = 1'b1;
                grp.fresh_cp   = {{(CP_W-BYTE_W){1'b0}}, data_byte};
                grp.fresh_used = USED_ONE;
            end else if (data_byte[7:5] == 3'b110) begin
                seq_next = SEQ_TWO;
                acc_next = {{(CP_W-5){1'b0}}, data_byte[4:0]};
            end else if (data_byte[7:4] == 4'b1110) begin
                seq_next = SEQ_THREE;
                acc_next = {{(CP_W-4){1'b0}}, data_byte[3:0]};
            end else if (data_byte[7:3] == 5'b11110) begin
                seq_next = SEQ_FOUR;
                acc_next = {{(CP_W-3){1'b0}}, data_byte[2:0]};
            end else begin
                grp.has_fresh  = 1'b1;
                grp.fresh_cp   = REPL_CP;
                grp.fresh_rep  = 1'b1;
                grp.fresh_used = USED_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= SEQ_IDLE;
            taken_reg <= '0;
            acc_reg   <= '0;
        end else if (take) begin
            seq_reg   <= seq_next;
            taken_reg <= taken_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
// UTF-8 stream decoder top level: byte input, code point output with result queue.
// One byte is taken per cycle while the output is not stalled and each byte causes
// at most one code point; a byte that causes several results (a broken sequence
// flushed as replacements, plus the byte's own result) holds s_tready low until the
// last of its results leaves the queue, as the output register gives one code point
// per cycle while m_tready allows. Bytes that only open or extend a sequence, and a
// zero byte with nothing pending, give no result.
module utf8_stream_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [u8sd_pkg::S_DATA_W-1:0]  s_tdata,  // [7:0] data_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [20:0] code_point, [21] is_replacement, [24:22] bytes_used, [31:25] zero
    output logic [u8sd_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast   // last_of_run
);
    import u8sd_pkg::*;

    group_t grp;
    logic   s_take;

    logic [RCNT_W-1:0] rep_cnt_reg,   rep_cnt_next;
    logic              has_fresh_reg, has_fresh_next;
    logic [CP_W-1:0]   fresh_cp_reg,  fresh_cp_next;
    logic              fresh_rep_reg, fresh_rep_next;
    logic [USED_W-1:0] fresh_used_reg, fresh_used_next;

    logic              m_valid_reg, m_valid_next;
    logic [CP_W-1:0]   m_cp_reg,    m_cp_next;
    logic              m_rep_reg,   m_rep_next;
    logic [USED_W-1:0] m_used_reg,  m_used_next;
    logic              m_last_reg,  m_last_next;

    logic out_free;
    logic buf_empty;
    logic buf_single;
    logic pop;

    assign out_free   = !m_valid_reg || m_tready;
    assign buf_empty  = (rep_cnt_reg == '0) && !has_fresh_reg;
    assign buf_single = ((rep_cnt_reg == '0) && has_fresh_reg)
                     || ((rep_cnt_reg == 2'd1) && !has_fresh_reg);
    assign pop        = out_free && !buf_empty;
    assign s_tready   = buf_empty || (buf_single && pop);
    assign s_take     = s_tvalid && s_tready;

    u8sd_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (s_take),
        .data_byte (s_tdata),
        .grp       (grp)
    );

    always_comb begin
        rep_cnt_next    = rep_cnt_reg;
        has_fresh_next  = has_fresh_reg;
        fresh_cp_next   = fresh_cp_reg;
        fresh_rep_next  = fresh_rep_reg;
        fresh_used_next = fresh_used_reg;
        m_valid_next    = m_valid_reg;
        m_cp_next       = m_cp_reg;
        m_rep_next      = m_rep_reg;
        m_used_next     = m_used_reg;
        m_last_next     = m_last_reg;

        if (out_free) begin
            m_valid_next = 1'b0;
        end
        if (pop) begin
            m_valid_next = 1'b1;
            if (rep_cnt_reg != '0) begin
                m_cp_next    = REPL_CP;
                m_rep_next   = 1'b1;
                m_used_next  = USED_ONE;
                m_last_next  = (rep_cnt_reg == 2'd1) && !has_fresh_reg;
                rep_cnt_next = rep_cnt_reg - 2'd1;
            end else begin
                m_cp_next      = fresh_cp_reg;
                m_rep_next     = fresh_rep_reg;
                m_used_next    = fresh_used_reg;
                m_last_next    = 1'b1;
                has_fresh_next = 1'b0;
            end
        end
        // The request is only taken once the queue drains this cycle.
        if (s_take) begin
            rep_cnt_next    = grp.rep_cnt;
            has_fresh_next  = grp.has_fresh;
            fresh_cp_next   = grp.fresh_cp;
            fresh_rep_next  = grp.fresh_rep;
            fresh_used_next = grp.fresh_used;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_cnt_reg   <= '0;
            has_fresh_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rep_cnt_reg   <= rep_cnt_next;
            has_fresh_reg <= has_fresh_next;
            m_valid_reg   <= m_valid_next;
        end
        fresh_cp_reg   <= fresh_cp_next;
        fresh_rep_reg  <= fresh_rep_next;
        fresh_used_reg <= fresh_used_next;
        m_cp_reg       <= m_cp_next;
        m_rep_reg      <= m_rep_next;
        m_used_reg     <= m_used_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-CP_W-1-USED_W){1'b0}}, m_used_reg, m_rep_reg, m_cp_reg};
    assign m_tlast  = m_last_reg;

    a_no_take_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (rep_cnt_reg != '0 && has_fresh_reg) |-> !s_tready)
        else $error("input taken while two or more results are queued");

    a_zero_no_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata == '0) |=> !has_fresh_reg)
        else $error("end-of-string byte queued a result of its own");

    a_multibyte_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_used_reg != USED_ONE) |-> (!m_rep_reg && m_last_reg))
        else $error("multi-byte code point is not a final, valid result");

endmodule
